// ----- rtl/drk_pkg.sv -----
// Shared types and constants for the descending rank assigner.
// No dependencies; every other file in rtl/ but drk_mem refers to this package by scoped names.
package drk_pkg;

    localparam int MAX_ITEMS_DEF  = 32;
    localparam int VALUE_BITS_DEF = 16;
    localparam int PRIO_W         = 16;
    localparam int RANK_W         = 7;
    localparam int VALUE_MAX_W    = 32;

    typedef struct packed {
        logic [PRIO_W-1:0] priority_value;
        logic              is_last;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              overflow;
        logic              last_rank;
    } t_result;

    // Control of the shared rank unit by the sequencer
    typedef struct packed {
        logic clear;
        logic step;
    } t_rank_ctl;

endpackage

// ----- rtl/drk_mem.sv -----
// Value store: one write port, one read port with registered read data.
// Depends on nothing outside this file.
module drk_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/drk_rank_unit.sv -----
// Shared compare unit and rank accumulator: one stored value against the pivot per cycle while step is set.
// Depends on drk_pkg for the control struct.
module drk_rank_unit #(
    parameter int MAX_ITEMS  = drk_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = drk_pkg::VALUE_BITS_DEF
) (
    input  logic                              i_clk,
    input  drk_pkg::t_rank_ctl                i_ctl,
    input  logic [VALUE_BITS-1:0]             i_pivot,
    input  logic [VALUE_BITS-1:0]             i_other,
    input  logic [$clog2(MAX_ITEMS)-1:0]      i_pivot_pos,
    input  logic [$clog2(MAX_ITEMS)-1:0]      i_other_pos,
    output logic [$clog2(MAX_ITEMS+1)-1:0]    o_rank
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [CNT_W-1:0] r_rank;
    logic [CNT_W-1:0] n_rank;
    logic             ahead;

    // The other item ranks ahead if larger, or equal and earlier
    assign ahead = (i_other > i_pivot) ||
                   ((i_other == i_pivot) && (i_other_pos < i_pivot_pos));

    assign n_rank = r_rank + CNT_W'(ahead);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_rank <= CNT_W'(1);
        end else if (i_ctl.step) begin
            r_rank <= n_rank;
        end
    end

    assign o_rank = n_rank;

endmodule

// ----- rtl/descending_rank_assigner.sv -----
// Loading: one value per cycle, start is taken whenever busy is low.
// Ranking: after the last value, each stored item in turn is fetched (ST_FETCH), latched as
// pivot (ST_PIVOT) and compared against all stored items in the shared unit (ST_CMP);
// its rank strobes at the end of that sweep, and busy drops as the final rank strobes.
// Results strobe for one cycle each and cannot be stalled.
// Reset (synchronous, active low) empties the list and clears overflow; the store is not cleared.
module descending_rank_assigner #(
    parameter int MAX_ITEMS  = drk_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = drk_pkg::VALUE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  drk_pkg::t_item   i_item,
    output logic             o_strobe,
    output drk_pkg::t_result o_result
);

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_PIVOT = 2'd2;
    localparam logic [1:0] ST_CMP   = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic                   r_ovf, n_ovf;
    logic [IDX_W-1:0]       r_i, n_i;
    logic [IDX_W-1:0]       r_j, n_j;
    logic [VALUE_BITS-1:0]  r_pivot;
    logic                   r_strobe, n_strobe;
    drk_pkg::t_result       r_result, n_result;

    logic                   accept;
    logic                   has_room;
    logic                   we;
    logic [IDX_W-1:0]       raddr;
    logic [VALUE_BITS-1:0]  wdata;
    logic [VALUE_BITS-1:0]  rdata;
    logic [drk_pkg::VALUE_MAX_W-1:0] prio_ext;
    logic [CNT_W-1:0]       rank;
    logic                   j_end;
    logic                   i_end;
    drk_pkg::t_rank_ctl     rank_ctl;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign has_room = (r_count < CNT_W'(MAX_ITEMS));
    assign we       = accept && has_room;
    assign prio_ext = drk_pkg::VALUE_MAX_W'(i_item.priority_value);
    assign wdata    = prio_ext[VALUE_BITS-1:0];
    assign j_end    = (CNT_W'(r_j) + CNT_W'(1)) == r_count;
    assign i_end    = (CNT_W'(r_i) + CNT_W'(1)) == r_count;

    drk_mem #(
        .DEPTH (MAX_ITEMS),
        .WIDTH (VALUE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    drk_rank_unit #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_rank (
        .i_clk       (i_clk),
        .i_ctl       (rank_ctl),
        .i_pivot     (r_pivot),
        .i_other     (rdata),
        .i_pivot_pos (r_i),
        .i_other_pos (r_j),
        .o_rank      (rank)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_i      = r_i;
        n_j      = r_j;
        n_strobe = 1'b0;
        n_result = r_result;
        raddr    = r_i;
        rank_ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (has_room) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_item.is_last) begin
                        n_i     = '0;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                raddr   = r_i;
                n_state = ST_PIVOT;
            end
            ST_PIVOT: begin
                // Pivot arrives now; start the sweep at entry zero
                raddr          = '0;
                n_j            = '0;
                rank_ctl.clear = 1'b1;
                n_state        = ST_CMP;
            end
            ST_CMP: begin
                rank_ctl.step = 1'b1;
                raddr         = r_j + IDX_W'(1);
                n_j           = r_j + IDX_W'(1);
                if (j_end) begin
                    n_strobe           = 1'b1;
                    n_result.rank      = drk_pkg::RANK_W'(rank);
                    n_result.overflow  = r_ovf;
                    n_result.last_rank = i_end;
                    if (i_end) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_i     = r_i + IDX_W'(1);
                        n_state = ST_FETCH;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_j      <= n_j;
        r_result <= n_result;
        if (r_state == ST_PIVOT) begin
            r_pivot <= rdata;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ----- rtl/drk_checker.sv -----
// Port-level checks for the descending rank assigner, bound to the top level.
// Depends on drk_pkg and descending_rank_assigner.
module drk_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input drk_pkg::t_item   i_item,
    input logic             o_strobe,
    input drk_pkg::t_result o_result
);

    // A final item starts the ranking run
    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_item.is_last |=> busy)
        else $error("block not busy after final item");

    a_rank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.rank != '0))
        else $error("rank of zero emitted");

    // Each rank needs at least a fetch and a compare
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results on adjacent cycles");

    a_final_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_rank |-> !busy)
        else $error("still busy on final rank");

    a_mid_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_rank |-> busy)
        else $error("idle before the run has ended");

endmodule

bind descending_rank_assigner drk_checker u_drk_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

// ----- tb/descending_rank_assigner_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for descending_rank_assigner: loads lists of priority values,
// predicts the descending rank of each entry and checks every rank strobe against it.
// Depends on drk_pkg and the descending_rank_assigner RTL only.
module descending_rank_assigner_tb;

    localparam int MAX_ITEMS      = drk_pkg::MAX_ITEMS_DEF;
    localparam int VALUE_BITS     = drk_pkg::VALUE_BITS_DEF;
    localparam int ITEM_TARGET    = 500;
    // a full list emits one rank per stored item, each after a fetch, a pivot latch and a full compare sweep
    localparam int DRAIN_CYCLES   = 2 * (MAX_ITEMS + 3);
    localparam int WATCHDOG_LIMIT = 20 * (MAX_ITEMS + 3) + 100;
    localparam int MAX_PRINTS     = 100;

    typedef struct {
        drk_pkg::t_item item;
        int unsigned    gap;
    } t_stim;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    logic             busy;
    drk_pkg::t_item   i_item  = '0;
    logic             o_strobe;
    drk_pkg::t_result o_result;

    t_stim                 pending_items[$];
    drk_pkg::t_result      expected_ranks[$];
    logic [VALUE_BITS-1:0] list_values[MAX_ITEMS];
    int unsigned           list_len      = 0;
    logic                  list_overflow = 1'b0;
    int unsigned           mismatches    = 0;
    int unsigned           wait_left     = 0;
    int unsigned           idle_cycles   = 0;
    logic                  took;
    t_stim                 next_stim;
    drk_pkg::t_result      want;

    always #10 i_clk = ~i_clk;

    descending_rank_assigner #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    task automatic report(input string msg);
        if (mismatches < MAX_PRINTS) begin
            $display("ERROR %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    // Store one accepted value; on the closing transaction rank the whole list.
    task automatic rank_list(input drk_pkg::t_item it);
        int unsigned      rank;
        drk_pkg::t_result res;
        if (list_len < MAX_ITEMS) begin
            list_values[list_len] = VALUE_BITS'(it.priority_value);
            list_len++;
        end else begin
            list_overflow = 1'b1;
        end
        if (it.is_last) begin
            for (int unsigned pos = 0; pos < list_len; pos++) begin
                rank = 1;
                for (int unsigned j = 0; j < list_len; j++) begin
                    if (list_values[j] > list_values[pos] ||
                        (list_values[j] == list_values[pos] && j < pos)) begin
                        rank++;
                    end
                end
                res.rank      = drk_pkg::RANK_W'(rank);
                res.overflow  = list_overflow;
                res.last_rank = (pos + 1 == list_len);
                expected_ranks.insert(expected_ranks.size(), res);
            end
            list_len      = 0;
            list_overflow = 1'b0;
        end
    endtask

    task automatic queue_item(input logic [drk_pkg::PRIO_W-1:0] value, input logic last,
                              input int unsigned gap);
        t_stim s;
        s.item.priority_value = value;
        s.item.is_last        = last;
        s.gap                 = gap;
        pending_items.insert(pending_items.size(), s);
    endtask

    // Driver: hold each transaction until busy drops, then pause for the drawn gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_item    <= '0;
            wait_left = 0;
        end else begin
            took = start && !busy;
            if (took) begin
                rank_list(i_item);
                wait_left = (pending_items.size() != 0) ? pending_items[0].gap : 0;
            end
            if (!start || took) begin
                if (wait_left != 0) begin
                    wait_left--;
                    start <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    next_stim = pending_items.pop_front();
                    i_item <= next_stim.item;
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe must match the oldest outstanding rank.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_ranks.size() == 0) begin
                report($sformatf("unexpected rank %0d overflow %0b last %0b",
                                 o_result.rank, o_result.overflow, o_result.last_rank));
            end else begin
                want = expected_ranks.pop_front();
                if (o_result.rank !== want.rank || o_result.overflow !== want.overflow ||
                    o_result.last_rank !== want.last_rank) begin
                    report($sformatf("rank %0d/%0d overflow %0b/%0b last %0b/%0b (got/exp)",
                                     o_result.rank, want.rank, o_result.overflow,
                                     want.overflow, o_result.last_rank, want.last_rank));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        logic [drk_pkg::PRIO_W-1:0] extremes[7];
        logic [drk_pkg::PRIO_W-1:0] ties[6];
        int unsigned                n_items;
        int unsigned                len;
        int unsigned                gap_max;
        logic                       tie_mode;
        logic [drk_pkg::PRIO_W-1:0] v;

        extremes = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE, 16'hFFFF};
        ties     = '{16'd5, 16'd5, 16'd5, 16'd7, 16'd7, 16'd0};

        // single-entry list, extreme values, then a list with repeated values
        queue_item('0, 1'b1, 0);
        foreach (extremes[k]) queue_item(extremes[k], k == 6, 0);
        foreach (ties[k]) queue_item(ties[k], k == 5, $urandom_range(0, 3));
        n_items = 14;

        // mostly short lists; now and then one near the store's depth that may fill or overrun it
        while (n_items < ITEM_TARGET) begin
            if ($urandom_range(0, 6) == 0) begin
                len = $urandom_range(MAX_ITEMS - 2, MAX_ITEMS + 4);
            end else begin
                len = $urandom_range(1, 8);
            end
            tie_mode = 1'($urandom_range(0, 1));
            gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 3;
            for (int unsigned k = 0; k < len; k++) begin
                if (tie_mode) begin
                    v = ($urandom_range(0, 1) == 1) ?
                        drk_pkg::PRIO_W'($urandom_range(0, 3)) :
                        ~drk_pkg::PRIO_W'($urandom_range(0, 3));
                end else begin
                    v = drk_pkg::PRIO_W'($urandom);
                end
                queue_item(v, k == len - 1, $urandom_range(0, gap_max));
            end
            n_items += len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_items.size() != 0 || start || expected_ranks.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && expected_ranks.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/drk_pkg.sv
rtl/drk_mem.sv
rtl/drk_rank_unit.sv
rtl/descending_rank_assigner.sv
rtl/drk_checker.sv
tb/descending_rank_assigner_tb.sv
